/* src/fsr_pkg.sv */
package fsr_pkg;

	localparam int NSLOT = 14;
	localparam int LAT   = 2 * NSLOT;

	localparam logic [31:0] SEED_SQRT      = 32'h5f375a86;
	localparam logic [31:0] SEED_RSQRT     = 32'h5f3759df;
	localparam logic [31:0] F_HALF         = 32'h3f000000;
	localparam logic [31:0] F_THREE_HALVES = 32'h3fc00000;
	localparam logic [31:0] F_DEF_NAN      = 32'hffc00000;
	localparam logic [31:0] F_INF          = 32'h7f800000;
	localparam logic [31:0] F_QUIET        = 32'h00400000;

	localparam logic FUNC_SQRT  = 1'b0;
	localparam logic FUNC_RSQRT = 1'b1;

	typedef enum logic [2:0] {
		SL_HALF,
		SL_P,
		SL_Q,
		SL_D,
		SL_Y,
		SL_OUT
	} slot_kind_t;

	typedef struct packed {
		logic        func;
		logic [31:0] x;
		logic [31:0] half;
		logic [31:0] y;
		logic [31:0] t;
	} ctx_t;

	typedef struct packed {
		logic               spec;
		logic [31:0]        spec_val;
		logic               sgn;
		logic [50:0]        mag;
		logic signed [10:0] ex;
	} fsr_mid_t;

	function automatic slot_kind_t slot_kind(input int k);
		slot_kind_t r;
		if (k == 0) begin
			r = SL_HALF;
		end else if (k == NSLOT - 1) begin
			r = SL_OUT;
		end else begin
			case ((k - 1) % 4)
				0:       r = SL_P;
				1:       r = SL_Q;
				2:       r = SL_D;
				default: r = SL_Y;
			endcase
		end
		return r;
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// first stage of a product: exact mantissa product and scale
	function automatic fsr_mid_t fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] prod;
		fsr_mid_t    m;
		ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma   = {a[30:23] != 8'd0, a[22:0]};
		mb   = {b[30:23] != 8'd0, b[22:0]};
		prod = 48'(ma) * 48'(mb);
		m.sgn = a[31] ^ b[31];
		m.mag = {3'b000, prod};
		m.ex  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd300;
		m.spec     = 1'b1;
		m.spec_val = 32'd0;
		if (is_nan(a)) begin
			m.spec_val = a | F_QUIET;
		end else if (is_nan(b)) begin
			m.spec_val = b | F_QUIET;
		end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
			m.spec_val = F_DEF_NAN;
		end else if (is_inf(a) || is_inf(b)) begin
			m.spec_val = {m.sgn, F_INF[30:0]};
		end else begin
			m.spec = 1'b0;
		end
		return m;
	endfunction

	// first stage of a difference: align with sticky, add or subtract
	function automatic fsr_mid_t fp_sub(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] bn;
		logic [31:0] lg;
		logic [31:0] sm;
		logic [7:0]  el;
		logic [7:0]  es;
		logic [23:0] ml;
		logic [23:0] ms;
		logic [7:0]  d;
		logic [5:0]  dcl;
		logic [99:0] al;
		logic [49:0] opa;
		logic [49:0] opb;
		fsr_mid_t    m;
		bn = {~b[31], b[30:0]};
		if (a[30:0] >= bn[30:0]) begin
			lg = a;
			sm = bn;
		end else begin
			lg = bn;
			sm = a;
		end
		el  = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
		es  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
		ml  = {lg[30:23] != 8'd0, lg[22:0]};
		ms  = {sm[30:23] != 8'd0, sm[22:0]};
		d   = el - es;
		dcl = (d > 8'd50) ? 6'd50 : d[5:0];
		al  = {ms, 76'd0} >> dcl;
		opa = {ml, 26'd0};
		opb = al[99:50] | {49'd0, |al[49:0]};
		if (lg[31] == sm[31]) begin
			m.mag = {1'b0, opa} + {1'b0, opb};
		end else begin
			m.mag = {1'b0, opa} - {1'b0, opb};
		end
		m.sgn = (m.mag == 51'd0) ? 1'b0 : lg[31];
		m.ex  = $signed({3'b000, el}) - 11'sd176;
		m.spec     = 1'b1;
		m.spec_val = 32'd0;
		if (is_nan(a)) begin
			m.spec_val = a | F_QUIET;
		end else if (is_nan(b)) begin
			m.spec_val = b | F_QUIET;
		end else if (is_inf(a) && is_inf(b) && (a[31] == b[31])) begin
			m.spec_val = F_DEF_NAN;
		end else if (is_inf(a)) begin
			m.spec_val = a;
		end else if (is_inf(b)) begin
			m.spec_val = bn;
		end else if (is_zero(a) && is_zero(b)) begin
			m.spec_val = {a[31] & bn[31], 31'd0};
		end else begin
			m.spec = 1'b0;
		end
		return m;
	endfunction

	// second stage: normalise, round to nearest even, pack
	function automatic logic [31:0] fp_round(input fsr_mid_t m);
		logic [5:0]         lead;
		logic signed [11:0] exw;
		logic signed [11:0] sh1;
		logic signed [11:0] sh2;
		logic signed [11:0] sh;
		logic [5:0]         amt;
		logic [103:0]       ext;
		logic [50:0]        kept;
		logic               g;
		logic               s;
		logic [24:0]        mant;
		logic signed [35:0] enc;
		logic [31:0]        r;
		lead = 6'd0;
		for (int i = 0; i < 51; i++) begin
			if (m.mag[i]) begin
				lead = 6'(i);
			end
		end
		exw = $signed({m.ex[10], m.ex});
		sh1 = $signed({6'd0, lead}) - 12'sd23;
		sh2 = -12'sd149 - exw;
		sh  = (sh1 > sh2) ? sh1 : sh2;
		if (sh > 12'sd0) begin
			amt  = (sh > 12'sd53) ? 6'd53 : sh[5:0];
			ext  = {m.mag, 53'd0} >> amt;
			kept = ext[103:53];
			g    = ext[52];
			s    = |ext[51:0];
			mant = kept[24:0] + {24'd0, g & (s | kept[0])};
		end else begin
			amt  = 6'(-sh);
			ext  = '0;
			kept = m.mag << amt;
			g    = 1'b0;
			s    = 1'b0;
			mant = kept[24:0];
		end
		enc = (($signed({{24{sh[11]}}, sh}) + $signed({{24{exw[11]}}, exw}) + 36'sd149) <<< 23)
			+ $signed({11'd0, mant});
		if (m.spec) begin
			r = m.spec_val;
		end else if (m.mag == 51'd0) begin
			r = {m.sgn, 31'd0};
		end else if (enc >= 36'sh7f800000) begin
			r = {m.sgn, F_INF[30:0]};
		end else begin
			r = {m.sgn, enc[30:0]};
		end
		return r;
	endfunction

endpackage

/* src/fast_sqrt_rsqrt_newton.sv */
// channel   ports                               handshake
// input     func, operand_bits                  taken when start && !busy
// result    result_bits                         valid for one cycle with done
//
// one item per cycle; each result passes both registers of every slot after its item is taken
// fourteen float operations in a chain, each a multiply or align stage then a round stage
// busy stays low: the pipeline never stalls and the receiver cannot hold results off
// arst_n clears the valid bits only; data registers are not reset
module fast_sqrt_rsqrt_newton import fsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);

	logic             accept;
	logic [31:0]      seed;
	logic [NSLOT-1:0] vin;
	logic [NSLOT-1:0] vld_s1;
	logic [NSLOT-1:0] vld_s2;
	ctx_t             ctx_in [NSLOT];
	ctx_t             ctx_s1 [NSLOT];
	fsr_mid_t         mid_s1 [NSLOT];
	ctx_t             ctx_s2 [NSLOT];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign seed   = ((func == FUNC_RSQRT) ? SEED_RSQRT : SEED_SQRT)
		- {operand_bits[31], operand_bits[31:1]};

	assign ctx_in[0] = '{func: func, x: operand_bits, half: 32'd0, y: seed, t: 32'd0};
	assign vin[0]    = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
			vld_s2 <= '0;
		end else begin
			vld_s1 <= vin;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar k = 0; k < NSLOT; k++) begin : g_slot
		localparam slot_kind_t KIND = slot_kind(k);
		localparam bit         LATE = (k > 4);

		fsr_mid_t    mid_a;
		logic [31:0] rnd;
		ctx_t        nxt;

		if (k > 0) begin : g_link
			assign ctx_in[k] = ctx_s2[k-1];
			assign vin[k]    = vld_s2[k-1];
		end

		always_comb begin
			case (KIND)
				SL_HALF: mid_a = fp_mul(ctx_in[k].x, F_HALF);
				SL_P:    mid_a = fp_mul(ctx_in[k].half, ctx_in[k].y);
				SL_Q:    mid_a = fp_mul(ctx_in[k].t, ctx_in[k].y);
				SL_D:    mid_a = fp_sub(F_THREE_HALVES, ctx_in[k].t);
				SL_Y:    mid_a = fp_mul(ctx_in[k].y, ctx_in[k].t);
				default: mid_a = fp_mul(ctx_in[k].x, ctx_in[k].y);
			endcase
		end

		always_ff @(posedge clk) begin
			ctx_s1[k] <= ctx_in[k];
			mid_s1[k] <= mid_a;
		end

		always_comb begin
			rnd = fp_round(mid_s1[k]);
			nxt = ctx_s1[k];
			case (KIND)
				SL_HALF: nxt.half = rnd;
				SL_P:    nxt.t = rnd;
				SL_Q:    nxt.t = rnd;
				SL_D:    nxt.t = rnd;
				SL_Y: begin
					// rsqrt keeps the first refined value
					if (!(LATE && nxt.func == FUNC_RSQRT)) begin
						nxt.y = rnd;
					end
				end
				SL_OUT: begin
					if (nxt.func == FUNC_SQRT) begin
						nxt.y = rnd;
					end
				end
				default: nxt = ctx_s1[k];
			endcase
		end

		always_ff @(posedge clk) begin
			ctx_s2[k] <= nxt;
		end
	end

	assign done        = vld_s2[NSLOT-1];
	assign result_bits = ctx_s2[NSLOT-1].y;

	a_done_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an item taken");

	a_stage_b_follows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> vld_s2 == $past(vld_s1))
		else $error("valid lost between stages");

	a_stage_a_follows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (vld_s1[NSLOT-1:1] == $past(vld_s2[NSLOT-2:0]))
			&& (vld_s1[0] == $past(accept)))
		else $error("valid lost between slots");

	a_nan_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && (operand_bits[30:23] == 8'hff)
			&& (operand_bits[22:0] != 23'd0), LAT)
		|-> result_bits[30:22] == 9'h1ff)
		else $error("nan operand gave a non nan result");

endmodule
